// ===== sv/rtpfu_pkg.sv =====
// Shared types, widths and reset values for the RTP H.264 FU-A packetizer.
package rtpfu_pkg;

	localparam int NAL_LEN_W  = 20;
	localparam int MAX_PAY_W  = 12;
	localparam int SEQ_W      = 16;
	localparam int TS_W       = 32;
	localparam int TS_STEP_W  = 16;
	localparam int PT_W       = 7;
	localparam int SSRC_W     = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int BURST_IDX_W = 4;

	localparam int DEF_PAYLOAD_LIMIT = 2048;
	localparam int DEF_LENGTH_BITS   = 20;

	localparam logic [SSRC_W-1:0]    RST_SSRC       = 32'h5f4d_f327;
	localparam logic [TS_STEP_W-1:0] RST_TS_STEP    = 16'd3600;
	localparam logic [MAX_PAY_W-1:0] RST_MAX_PAY    = 12'd1400;
	localparam logic [PT_W-1:0]      RST_PT         = 7'd96;
	localparam logic [SEQ_W-1:0]     RST_SEQ_START  = 16'd100;
	localparam logic [TS_W-1:0]      RST_TS_START   = 32'd100;

	localparam logic [7:0] RTP_BYTE0  = 8'h80;
	localparam logic [4:0] FU_A_TYPE  = 5'd28;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SSRC     = 3'd0,
		CFG_TS_STEP  = 3'd1,
		CFG_MAX_PAY  = 3'd2,
		CFG_PT       = 3'd3,
		CFG_SEQ_START = 3'd4,
		CFG_TS_START = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0]           data_byte;
		logic                 first_of_nal;
		logic [NAL_LEN_W-1:0] nal_length;
	} nal_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       packet_end;
		logic       run_last;
	} pkt_item_t;

	typedef struct packed {
		logic [SEQ_W-1:0]     seq;
		logic [TS_W-1:0]      ts;
		logic [7:0]           saved_hdr;
		logic [NAL_LEN_W-1:0] bytes_remaining;
		logic [MAX_PAY_W-1:0] fragment_fill;
		logic [MAX_PAY_W-1:0] frag_size;
		logic                 fragmenting;
		logic                 first_frag_pending;
	} nal_state_t;

	// What one NAL byte asks the output stage to send.
	typedef struct packed {
		logic       emit;
		logic       hdr;
		logic       fu;
		logic [7:0] fu_ind;
		logic [7:0] fu_hdr;
		logic [7:0] data;
		logic       pkt_end;
	} step_out_t;

endpackage

// ===== sv/rtpfu_step.sv =====
// Per-byte packetizing decision: next NAL state and the packet bytes to send.
module rtpfu_step #(
	parameter int PAYLOAD_LIMIT = rtpfu_pkg::DEF_PAYLOAD_LIMIT,
	parameter int LENGTH_BITS   = rtpfu_pkg::DEF_LENGTH_BITS
) (
	input  rtpfu_pkg::nal_item_t                     item,
	input  rtpfu_pkg::nal_state_t                    st,
	input  logic [rtpfu_pkg::MAX_PAY_W-1:0]          max_payload,
	input  logic [rtpfu_pkg::TS_STEP_W-1:0]          ts_step,
	output rtpfu_pkg::nal_state_t                    st_next,
	output rtpfu_pkg::step_out_t                     res
);
	import rtpfu_pkg::*;

	localparam logic [NAL_LEN_W-1:0] LEN_MASK = (LENGTH_BITS >= NAL_LEN_W) ?
		{NAL_LEN_W{1'b1}} : NAL_LEN_W'((64'd1 << LENGTH_BITS) - 64'd1);

	logic [NAL_LEN_W-1:0] len;
	logic [NAL_LEN_W-1:0] rem_dec;
	logic [NAL_LEN_W-1:0] eff_ext;
	logic [MAX_PAY_W-1:0] eff;
	logic [MAX_PAY_W-1:0] size_raw;
	logic [MAX_PAY_W-1:0] size;
	logic [MAX_PAY_W-1:0] fill_inc;
	logic [MAX_PAY_W-1:0] cur_frag_size;
	logic                 e_bit;
	logic                 frag_end;
	logic                 new_frag;

	// The effective limit is max_payload clamped to 2..PAYLOAD_LIMIT.
	assign eff = (max_payload < MAX_PAY_W'(2)) ? MAX_PAY_W'(2) :
		((32'(max_payload) > PAYLOAD_LIMIT) ? MAX_PAY_W'(PAYLOAD_LIMIT) : max_payload);
	assign eff_ext = NAL_LEN_W'(eff);

	assign len = ((item.nal_length & LEN_MASK) == '0) ? NAL_LEN_W'(1) :
		(item.nal_length & LEN_MASK);
	assign rem_dec = st.bytes_remaining - NAL_LEN_W'(1);

	assign size_raw = (st.bytes_remaining < eff_ext) ?
		st.bytes_remaining[MAX_PAY_W-1:0] : eff;
	// A first fragment that would also be the last gives up one byte.
	assign size = (st.first_frag_pending && (NAL_LEN_W'(size_raw) == st.bytes_remaining)) ?
		size_raw - MAX_PAY_W'(1) : size_raw;
	assign e_bit = (NAL_LEN_W'(size) == st.bytes_remaining);

	assign new_frag      = (st.fragment_fill == '0);
	assign cur_frag_size = new_frag ? size : st.frag_size;
	assign fill_inc      = st.fragment_fill + MAX_PAY_W'(1);
	assign frag_end      = (fill_inc >= cur_frag_size) || (rem_dec == '0);

	always_comb begin
		st_next = st;
		res     = '0;
		res.data = item.data_byte;
		if (item.first_of_nal) begin
			st_next.ts              = st.ts + TS_W'(ts_step);
			st_next.fragment_fill   = '0;
			st_next.frag_size       = '0;
			st_next.bytes_remaining = len - NAL_LEN_W'(1);
			if (len <= eff_ext) begin
				st_next.fragmenting        = 1'b0;
				st_next.first_frag_pending = 1'b0;
				st_next.seq                = st.seq + SEQ_W'(1);
				res.emit    = 1'b1;
				res.hdr     = 1'b1;
				res.pkt_end = (len == NAL_LEN_W'(1));
			end else begin
				st_next.fragmenting        = 1'b1;
				st_next.first_frag_pending = 1'b1;
				st_next.saved_hdr          = item.data_byte;
			end
		end else if (st.bytes_remaining != '0) begin
			st_next.bytes_remaining = rem_dec;
			res.emit = 1'b1;
			if (!st.fragmenting) begin
				res.pkt_end = (rem_dec == '0);
			end else begin
				if (new_frag) begin
					st_next.frag_size          = size;
					st_next.first_frag_pending = 1'b0;
					st_next.seq                = st.seq + SEQ_W'(1);
					res.hdr    = 1'b1;
					res.fu     = 1'b1;
					res.fu_ind = {st.saved_hdr[7:5], FU_A_TYPE};
					res.fu_hdr = {st.first_frag_pending, e_bit, 1'b0, st.saved_hdr[4:0]};
				end
				st_next.fragment_fill = frag_end ? '0 : fill_inc;
				res.pkt_end = frag_end;
				if (rem_dec == '0) begin
					st_next.fragmenting = 1'b0;
				end
			end
		end
	end

endmodule

// ===== sv/rtp_h264_fua_packetizer.sv =====
// Top level of the RTP packetizer for H.264 NAL units with FU-A fragmentation.
// NAL bytes enter one per transaction on the nal channel and leave as RTP packet bytes on
// the pkt channel, one byte per cycle at most. A NAL byte that adds no packet header is
// sent as a single byte, and such items stream back to back while the receiver does not
// stall; a byte that opens a packet is sent as a burst of 13 bytes (single NAL packet) or
// 15 bytes (FU-A fragment), and the input stalls until the last byte of that burst is
// taken. The header byte of a fragmented NAL produces no output. Configuration writes
// are always ready and must only be issued while no packet bytes are outstanding; writing
// the start sequence number or timestamp reloads the running value at once.
module rtp_h264_fua_packetizer #(
	parameter int PAYLOAD_LIMIT = rtpfu_pkg::DEF_PAYLOAD_LIMIT,
	parameter int LENGTH_BITS   = rtpfu_pkg::DEF_LENGTH_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 nal_valid,
	output logic                                 nal_stall,
	input  rtpfu_pkg::nal_item_t                 nal,
	output logic                                 pkt_valid,
	input  logic                                 pkt_stall,
	output rtpfu_pkg::pkt_item_t                 pkt,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rtpfu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rtpfu_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import rtpfu_pkg::*;

	localparam int HDR_BYTES = 12;
	localparam logic [BURST_IDX_W-1:0] IDX_HDR_TOP = BURST_IDX_W'(HDR_BYTES - 1);
	localparam logic [BURST_IDX_W-1:0] IDX_FU_IND  = BURST_IDX_W'(HDR_BYTES);
	localparam logic [BURST_IDX_W-1:0] IDX_FU_HDR  = BURST_IDX_W'(HDR_BYTES + 1);
	localparam logic [BURST_IDX_W-1:0] IDX_FU_LAST = BURST_IDX_W'(HDR_BYTES + 2);
	localparam nal_state_t ST_RST = nal_state_t'({RST_SEQ_START, RST_TS_START,
		{($bits(nal_state_t) - SEQ_W - TS_W){1'b0}}});

	logic [SSRC_W-1:0]    ssrc_q;
	logic [TS_STEP_W-1:0] ts_step_q;
	logic [MAX_PAY_W-1:0] max_pay_q;
	logic [PT_W-1:0]      pt_q;

	nal_item_t  item_s1;
	logic       valid_s1;
	nal_state_t st_q;
	nal_state_t st_d;
	nal_state_t st_next;
	step_out_t  res;

	logic                   burst_valid_q;
	logic [BURST_IDX_W-1:0] idx_q;
	logic [BURST_IDX_W-1:0] last_q;
	logic [7:0]             fu_ind_q;
	logic [7:0]             fu_hdr_q;
	logic [7:0]             data_q;
	logic                   end_q;

	logic                      cfg_wr;
	logic                      burst_done;
	logic                      take_s1;
	logic [HDR_BYTES-1:0][7:0] hdr_pk;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	assign burst_done = burst_valid_q && !pkt_stall && (idx_q == last_q);
	assign take_s1    = valid_s1 && (!burst_valid_q || burst_done);
	assign nal_stall  = valid_s1 && !take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ssrc_q      <= RST_SSRC;
			ts_step_q   <= RST_TS_STEP;
			max_pay_q   <= RST_MAX_PAY;
			pt_q        <= RST_PT;
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_SSRC:      ssrc_q      <= cfg_data;
				CFG_TS_STEP:   ts_step_q   <= cfg_data[TS_STEP_W-1:0];
				CFG_MAX_PAY:   max_pay_q   <= cfg_data[MAX_PAY_W-1:0];
				CFG_PT:        pt_q        <= cfg_data[PT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (nal_valid && !nal_stall) begin
			valid_s1 <= 1'b1;
		end else if (take_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (nal_valid && !nal_stall) begin
			item_s1 <= nal;
		end
	end

	rtpfu_step #(
		.PAYLOAD_LIMIT (PAYLOAD_LIMIT),
		.LENGTH_BITS   (LENGTH_BITS)
	) u_step (
		.item        (item_s1),
		.st          (st_q),
		.max_payload (max_pay_q),
		.ts_step     (ts_step_q),
		.st_next     (st_next),
		.res         (res)
	);

	// Start loads override the running count; user must write only when idle (unenforced).
	always_comb begin
		st_d = take_s1 ? st_next : st_q;
		if (cfg_wr && (cfg_index == CFG_SEQ_START)) begin
			st_d.seq = cfg_data[SEQ_W-1:0];
		end
		if (cfg_wr && (cfg_index == CFG_TS_START)) begin
			st_d.ts = cfg_data[TS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RST;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_valid_q <= 1'b0;
			idx_q         <= '0;
			last_q        <= '0;
		end else if (take_s1) begin
			burst_valid_q <= res.emit;
			idx_q         <= '0;
			last_q        <= res.fu ? IDX_FU_LAST : (res.hdr ? IDX_FU_IND : '0);
		end else if (burst_valid_q && !pkt_stall) begin
			if (idx_q == last_q) begin
				burst_valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + BURST_IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			fu_ind_q <= res.fu_ind;
			fu_hdr_q <= res.fu_hdr;
			data_q   <= res.data;
			end_q    <= res.pkt_end;
		end
	end

	// The running sequence number and timestamp stay put until the burst is drained.
	assign hdr_pk = {RTP_BYTE0, 1'b0, pt_q, st_q.seq, st_q.ts, ssrc_q};

	assign pkt_valid = burst_valid_q;

	always_comb begin
		pkt = '0;
		if (idx_q == last_q) begin
			pkt.out_byte   = data_q;
			pkt.packet_end = end_q;
			pkt.run_last   = 1'b1;
		end else if (idx_q == IDX_FU_IND) begin
			pkt.out_byte = fu_ind_q;
		end else if (idx_q == IDX_FU_HDR) begin
			pkt.out_byte = fu_hdr_q;
		end else begin
			pkt.out_byte = hdr_pk[IDX_HDR_TOP - idx_q];
		end
	end

	a_idx_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		burst_valid_q |-> (idx_q <= last_q))
		else $error("burst byte counter ran past the last byte");

	a_hdr_first_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(pkt_valid && (idx_q == '0) && (last_q != '0)) |-> (pkt.out_byte == RTP_BYTE0))
		else $error("packet does not open with the RTP version byte");

	a_frag_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.fragmenting |-> (st_q.bytes_remaining != '0))
		else $error("fragmenting with no NAL bytes left");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !take_s1) |=> (valid_s1 && $stable(item_s1)))
		else $error("input register lost an item that was not taken");

endmodule

// ===== tb/rtpfu_checker.sv =====
// Checker for the RTP H.264 packetizer: watches all channels, predicts packet bytes, compares.
`timescale 1ns / 1ps

module rtpfu_checker #(
	parameter int PAYLOAD_LIMIT = rtpfu_pkg::DEF_PAYLOAD_LIMIT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             nal_valid,
	input  logic                             nal_stall,
	input  rtpfu_pkg::nal_item_t             nal,
	input  logic                             pkt_valid,
	input  logic                             pkt_stall,
	input  rtpfu_pkg::pkt_item_t             pkt,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [rtpfu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rtpfu_pkg::CFG_DATA_W-1:0] cfg_data,
	output int unsigned                      error_count,
	output int unsigned                      pending
);
	import rtpfu_pkg::*;

	// Register copies.
	logic [SSRC_W-1:0]    ssrc;
	logic [TS_STEP_W-1:0] ts_step;
	logic [MAX_PAY_W-1:0] max_pay;
	logic [PT_W-1:0]      pt;

	// Packetizer state.
	logic [SEQ_W-1:0]     seq_num;
	logic [TS_W-1:0]      cur_ts;
	logic [7:0]           nal_hdr;
	logic [NAL_LEN_W-1:0] remaining;
	logic [MAX_PAY_W-1:0] fill;
	logic [MAX_PAY_W-1:0] frag_len;
	logic                 in_fu;
	logic                 s_pending;

	pkt_item_t   pkt_bytes_q[$];
	int unsigned errors = 0;

	function automatic int unsigned payload_cap();
		if (max_pay < 2)
			return 2;
		if (max_pay > PAYLOAD_LIMIT)
			return PAYLOAD_LIMIT;
		return 32'(max_pay);
	endfunction

	task automatic queue_byte(input logic [7:0] b, input logic closes);
		pkt_item_t x;
		x.out_byte = b;
		x.packet_end = closes;
		x.run_last = 1'b0;
		pkt_bytes_q.push_back(x);
	endtask

	task automatic queue_rtp_header();
		seq_num = seq_num + 1'b1;
		queue_byte(RTP_BYTE0, 1'b0);
		queue_byte({1'b0, pt}, 1'b0);
		queue_byte(seq_num[15:8], 1'b0);
		queue_byte(seq_num[7:0], 1'b0);
		queue_byte(cur_ts[31:24], 1'b0);
		queue_byte(cur_ts[23:16], 1'b0);
		queue_byte(cur_ts[15:8], 1'b0);
		queue_byte(cur_ts[7:0], 1'b0);
		queue_byte(ssrc[31:24], 1'b0);
		queue_byte(ssrc[23:16], 1'b0);
		queue_byte(ssrc[15:8], 1'b0);
		queue_byte(ssrc[7:0], 1'b0);
	endtask

	task automatic predict_nal(input nal_item_t it);
		int unsigned n_prior;
		int unsigned cap;
		int unsigned len;
		int unsigned size;
		logic        s_bit;
		logic        e_bit;
		logic        closes;
		pkt_item_t   tail;
		n_prior = pkt_bytes_q.size();
		cap = payload_cap();
		if (it.first_of_nal) begin
			len = 32'(it.nal_length);
			if (len == 0)
				len = 1;
			cur_ts = cur_ts + TS_W'(ts_step);
			fill = '0;
			frag_len = '0;
			remaining = NAL_LEN_W'(len - 1);
			if (len <= cap) begin
				in_fu = 1'b0;
				s_pending = 1'b0;
				queue_rtp_header();
				queue_byte(it.data_byte, remaining == 0);
			end else begin
				// The header byte is held back for the FU indicator and FU header.
				in_fu = 1'b1;
				s_pending = 1'b1;
				nal_hdr = it.data_byte;
			end
		end else if (remaining != 0) begin
			if (!in_fu) begin
				remaining = remaining - 1'b1;
				queue_byte(it.data_byte, remaining == 0);
			end else begin
				if (fill == 0) begin
					size = (remaining < cap) ? 32'(remaining) : cap;
					s_bit = s_pending;
					// A lone fragment would carry S and E together, so the first one is shortened.
					if (s_bit && size == remaining)
						size = 32'(remaining) - 1;
					e_bit = (size == remaining);
					frag_len = MAX_PAY_W'(size);
					s_pending = 1'b0;
					queue_rtp_header();
					queue_byte({nal_hdr[7:5], FU_A_TYPE}, 1'b0);
					queue_byte({s_bit, e_bit, 1'b0, nal_hdr[4:0]}, 1'b0);
				end
				fill = fill + 1'b1;
				remaining = remaining - 1'b1;
				closes = (fill >= frag_len) || (remaining == 0);
				queue_byte(it.data_byte, closes);
				if (closes)
					fill = '0;
				if (remaining == 0)
					in_fu = 1'b0;
			end
		end
		if (pkt_bytes_q.size() > n_prior) begin
			tail = pkt_bytes_q.pop_back();
			tail.run_last = 1'b1;
			pkt_bytes_q.push_back(tail);
		end
	endtask

	task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		case (cfg_idx_t'(idx))
			CFG_SSRC: ssrc = d;
			CFG_TS_STEP: ts_step = d[TS_STEP_W-1:0];
			CFG_MAX_PAY: max_pay = d[MAX_PAY_W-1:0];
			CFG_PT: pt = d[PT_W-1:0];
			CFG_SEQ_START: seq_num = d[SEQ_W-1:0];
			CFG_TS_START: cur_ts = d[TS_W-1:0];
			default: ;
		endcase
	endtask

	task automatic check_pkt(input pkt_item_t got);
		pkt_item_t want;
		if (pkt_bytes_q.size() == 0) begin
			$error("unexpected packet byte %02h (packet_end %0b, run_last %0b)",
				got.out_byte, got.packet_end, got.run_last);
			errors++;
		end else begin
			want = pkt_bytes_q.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
				errors++;
			end
			if (got.packet_end !== want.packet_end) begin
				$error("packet_end: expected %0b, got %0b", want.packet_end, got.packet_end);
				errors++;
			end
			if (got.run_last !== want.run_last) begin
				$error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
				errors++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ssrc = RST_SSRC;
			ts_step = RST_TS_STEP;
			max_pay = RST_MAX_PAY;
			pt = RST_PT;
			seq_num = RST_SEQ_START;
			cur_ts = RST_TS_START;
			nal_hdr = '0;
			remaining = '0;
			fill = '0;
			frag_len = '0;
			in_fu = 1'b0;
			s_pending = 1'b0;
			pkt_bytes_q.delete();
			pending <= 0;
			error_count <= errors;
		end else begin
			if (cfg_valid && cfg_ready)
				apply_cfg(cfg_index, cfg_data);
			// Expectations go in before the output is checked.
			if (nal_valid && !nal_stall)
				predict_nal(nal);
			if (pkt_valid && !pkt_stall)
				check_pkt(pkt);
			pending <= pkt_bytes_q.size();
			error_count <= errors;
		end
	end

endmodule

// ===== tb/tb.sv =====
// Testbench top: drives NAL bytes and register writes into the packetizer and gives the verdict.
`timescale 1ns / 1ps

module tb;
	import rtpfu_pkg::*;

	localparam int IDLE_LIMIT   = 4000;
	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 20;
	localparam int PHASE_ITEMS  = 25;
	localparam int RANDOM_PHASES = 5;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  nal_valid = 1'b0;
	logic                  nal_stall;
	nal_item_t             nal = '0;
	logic                  pkt_valid;
	logic                  pkt_stall = 1'b0;
	pkt_item_t             pkt;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int unsigned           mismatches;
	int unsigned           outstanding;

	// Stimulus bookkeeping.
	logic        offering = 1'b0;
	int unsigned burst_left = 0;
	int unsigned cur_cap = 1400;
	int unsigned unit_items = 0;
	logic        hold_req = 1'b0;

	// Receiver stall pattern.
	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;
	int unsigned stall_mode = 0;
	int unsigned mode_left = 0;
	logic [7:0]  stall_pat = 8'h00;
	int unsigned pat_pos = 0;
	int unsigned idle_cycles = 0;

	rtp_h264_fua_packetizer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.nal_valid (nal_valid),
		.nal_stall (nal_stall),
		.nal       (nal),
		.pkt_valid (pkt_valid),
		.pkt_stall (pkt_stall),
		.pkt       (pkt),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	rtpfu_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.nal_valid   (nal_valid),
		.nal_stall   (nal_stall),
		.nal         (nal),
		.pkt_valid   (pkt_valid),
		.pkt_stall   (pkt_stall),
		.pkt         (pkt),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.error_count (mismatches),
		.pending     (outstanding)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Receiver: random stall modes, plus one long hold-off on request.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			pkt_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			pkt_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(20, 120);
				stall_pat <= 8'($urandom_range(0, 255));
			end else begin
				mode_left <= mode_left - 1;
			end
			pat_pos <= pat_pos + 1;
			case (stall_mode)
				0: pkt_stall <= 1'b0;
				1: pkt_stall <= ($urandom_range(0, 3) == 0);
				2: pkt_stall <= ($urandom_range(0, 3) != 0);
				default: pkt_stall <= stall_pat[pat_pos[2:0]];
			endcase
		end
	end

	// Watchdog on cycles with no transaction on any channel.
	always @(posedge clk) begin
		if (!arst_n || (nal_valid && !nal_stall) || (pkt_valid && !pkt_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_item(input nal_item_t it);
		int unsigned gap;
		nal <= it;
		nal_valid <= 1'b1;
		offering = 1'b1;
		do
			@(posedge clk);
		while (nal_stall);
		if (burst_left != 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			nal_valid <= 1'b0;
			offering = 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) :
				$urandom_range(0, 8);
		end
	endtask

	// Sends the first n_send bytes of a NAL unit; fixed below zero means random data.
	task automatic send_unit(input logic [NAL_LEN_W-1:0] len, input int unsigned n_send,
			input int fixed);
		nal_item_t   it;
		int unsigned i;
		for (i = 0; i < n_send; i++) begin
			it.first_of_nal = (i == 0);
			it.nal_length = (i == 0) ? len : NAL_LEN_W'($urandom_range(0, 20'hFFFFF));
			it.data_byte = (fixed < 0) ? 8'($urandom_range(0, 255)) : fixed[7:0];
			send_item(it);
			unit_items++;
		end
	endtask

	task automatic send_stray(input logic [7:0] b);
		nal_item_t it;
		it.first_of_nal = 1'b0;
		it.nal_length = NAL_LEN_W'($urandom_range(0, 20'hFFFFF));
		it.data_byte = b;
		send_item(it);
		unit_items++;
	endtask

	// Lets every expected byte drain, then some spare cycles for a header byte still in flight.
	task automatic quiesce();
		if (offering) begin
			nal_valid <= 1'b0;
			offering = 1'b0;
		end
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
		cfg_index <= idx;
		cfg_data <= d;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
	endtask

	task automatic set_config(input logic [31:0] ssrc, input logic [15:0] step,
			input logic [11:0] maxp, input logic [6:0] ptype, input logic [15:0] seq0,
			input logic [31:0] ts0);
		quiesce();
		cfg_write(CFG_SSRC, ssrc);
		cfg_write(CFG_TS_STEP, CFG_DATA_W'(step));
		cfg_write(CFG_MAX_PAY, CFG_DATA_W'(maxp));
		cfg_write(CFG_PT, CFG_DATA_W'(ptype));
		cfg_write(CFG_SEQ_START, CFG_DATA_W'(seq0));
		cfg_write(CFG_TS_START, ts0);
		cfg_valid <= 1'b0;
		cur_cap = (maxp < 2) ? 2 : (maxp > DEF_PAYLOAD_LIMIT) ? DEF_PAYLOAD_LIMIT : 32'(maxp);
	endtask

	task automatic random_config();
		logic [11:0] maxp;
		logic [15:0] step;
		logic [15:0] seq0;
		case ($urandom_range(0, 9))
			0: maxp = 12'd0;
			1: maxp = 12'd1;
			2: maxp = 12'd2048;
			3: maxp = 12'hFFF;
			4: maxp = 12'($urandom_range(9, 4095));
			default: maxp = 12'($urandom_range(2, 8));
		endcase
		case ($urandom_range(0, 3))
			0: step = 16'h0000;
			1: step = 16'hFFFF;
			default: step = 16'($urandom_range(0, 65535));
		endcase
		seq0 = ($urandom_range(0, 3) == 0) ? 16'hFFFE : 16'($urandom_range(0, 65535));
		set_config($urandom(), step, maxp, 7'($urandom_range(0, 127)), seq0, $urandom());
	endtask

	// Mostly complete NAL units of up to 3*cap+2 or 24 bytes (cap > 16); the rest is noise.
	task automatic random_phase();
		int unsigned len;
		int unsigned top_len;
		unit_items = 0;
		top_len = (cur_cap <= 16) ? 3 * cur_cap + 2 : 24;
		while (unit_items < PHASE_ITEMS) begin
			case ($urandom_range(0, 9))
				0: send_stray(8'($urandom_range(0, 255)));
				1: begin
					len = $urandom_range(2, top_len);
					send_unit(NAL_LEN_W'(len), $urandom_range(1, len - 1), -1);
				end
				2: send_unit(NAL_LEN_W'($urandom_range(0, 20'hFFFFF)), $urandom_range(1, 4), -1);
				3: begin
					len = (cur_cap <= 16) ? cur_cap + $urandom_range(0, 2) : $urandom_range(1, 20);
					send_unit(NAL_LEN_W'(len), len, -1);
				end
				default: begin
					len = $urandom_range(1, top_len);
					send_unit(NAL_LEN_W'(len), len, -1);
				end
			endcase
		end
	endtask

	initial begin
		int unsigned p;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: zero length, stray byte, data extremes, both kinds of abandoned unit.
		send_unit(20'd0, 1, 8'h00);
		send_stray(8'hFF);
		send_unit(20'd3, 3, 8'hFF);
		send_unit(20'd5, 2, -1);
		send_unit(20'hFFFFF, 3, -1);

		// Payload limit below range, sequence and timestamp about to wrap.
		set_config(32'h0000_0000, 16'hFFFF, 12'd0, 7'd127, 16'hFFFF, 32'hFFFF_FFF0);
		send_unit(20'd2, 2, -1);
		send_unit(20'd3, 3, -1);
		send_unit(20'd6, 6, -1);

		// Payload limit above range; a unit one byte over the limit is started and left open.
		set_config(32'hFFFF_FFFF, 16'h0000, 12'hFFF, 7'd0, 16'h0000, 32'h0000_0000);
		send_unit(20'd2049, 3, -1);

		set_config(32'h1234_5678, 16'd3600, 12'd1, 7'd96, 16'd100, 32'd100);
		send_unit(20'd4, 4, -1);

		for (p = 0; p < RANDOM_PHASES; p++) begin
			random_config();
			if (p == 0)
				hold_req <= 1'b1;
			random_phase();
		end

		quiesce();
		if (mismatches == 0 && outstanding == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
